>>> hdl/spte_pkg.sv
`timescale 1ns / 1ps
// shared types and codes for the sorted pair table engine
package spte_pkg;

	localparam logic [1:0] MODE_INS = 2'd0;
	localparam logic [1:0] MODE_DEL = 2'd1;
	localparam logic [1:0] MODE_LKP = 2'd2;
	localparam logic [1:0] MODE_REV = 2'd3;

	localparam logic [1:0] ST_DONE = 2'd0;
	localparam logic [1:0] ST_MISS = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	typedef struct packed {
		logic load;
		logic init;
		logic rd;
		logic eval;
		logic place;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic init_fin;
		logic ev_hold;
		logic ev_fin;
		logic ev_place;
		logic out_free;
	} stat_t;

endpackage

>>> hdl/spte_ctrl.sv
`timescale 1ns / 1ps
// sequencing state machine for the sorted pair table engine
module spte_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  spte_pkg::stat_t st,
	output spte_pkg::cmd_t  cmd
);
	import spte_pkg::*;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_INIT  = 3'd1;
	localparam logic [2:0] S_READ  = 3'd2;
	localparam logic [2:0] S_EVAL  = 3'd3;
	localparam logic [2:0] S_PLACE = 3'd4;
	localparam logic [2:0] S_FIN   = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				cmd.load = in_valid;
				if (in_valid) begin
					state_d = S_INIT;
				end
			end
			S_INIT: begin
				cmd.init = 1'b1;
				state_d  = st.init_fin ? S_FIN : S_READ;
			end
			S_READ: begin
				cmd.rd  = 1'b1;
				state_d = S_EVAL;
			end
			S_EVAL: begin
				cmd.eval = 1'b1;
				priority if (st.ev_hold) begin
					state_d = S_EVAL;
				end else if (st.ev_fin) begin
					state_d = S_FIN;
				end else if (st.ev_place) begin
					state_d = S_PLACE;
				end else begin
					state_d = S_READ;
				end
			end
			S_PLACE: begin
				cmd.place = 1'b1;
				state_d   = S_FIN;
			end
			S_FIN: begin
				cmd.emit = st.out_free;
				if (st.out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

>>> hdl/spte_datapath.sv
`timescale 1ns / 1ps
// table memory, entry count, search registers and result register
module spte_datapath #(
	parameter int CAPACITY   = 32,
	parameter int WORD_BYTES = 8
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic [1:0]      mode,
	input  logic [63:0]     key_word,
	input  logic [63:0]     value_word,
	input  spte_pkg::cmd_t  cmd,
	output spte_pkg::stat_t st,
	input  logic            out_stall,
	output logic            out_valid,
	output logic [1:0]      status,
	output logic [63:0]     found_key,
	output logic [63:0]     found_value,
	output logic            last
);
	import spte_pkg::*;

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int DROP = 8 * (8 - WORD_BYTES);
	localparam logic [63:0] TRIM = {64{1'b1}} << DROP;
	localparam logic signed [CW:0] ONE_SX = (CW+1)'(1);

	logic [127:0]       mem_q [CAPACITY];
	logic [127:0]       rdata_s1;
	logic [1:0]         mode_q;
	logic [63:0]        key_q;
	logic [63:0]        val_q;
	logic [CW-1:0]      cnt_q;
	logic [AW-1:0]      idx_q;
	logic signed [CW:0] lo_q;
	logic signed [CW:0] hi_q;
	logic               found_q;
	logic               pend_v_q;
	logic [1:0]         pend_st_q;
	logic [63:0]        pend_key_q;
	logic [63:0]        pend_val_q;
	logic               out_valid_q;
	logic [1:0]         out_st_q;
	logic [63:0]        out_key_q;
	logic [63:0]        out_val_q;
	logic               out_last_q;

	logic [63:0]        rkey;
	logic [63:0]        rval;
	logic               full;
	logic               empty;
	logic [CW-1:0]      cnt_m1;
	logic               last_idx;
	logic               key_gt;
	logic               key_eq;
	logic               key_lt;
	logic               val_eq;
	logic               out_free;
	logic signed [CW:0] idx_sx;
	logic signed [CW:0] nlo;
	logic signed [CW:0] nhi;
	logic               lkp_end;
	logic [CW:0]        msum;
	logic               ins_now;
	logic               do_eval;
	logic               rev_emit;
	logic               we;
	logic [AW-1:0]      waddr;
	logic [127:0]       wdata;

	assign rkey     = rdata_s1[127:64];
	assign rval     = rdata_s1[63:0];
	assign full     = (cnt_q == CW'(CAPACITY));
	assign empty    = (cnt_q == '0);
	assign cnt_m1   = cnt_q - 1'b1;
	assign last_idx = (CW'(idx_q) == cnt_m1);
	assign key_gt   = (rkey > key_q);
	assign key_eq   = (rkey == key_q);
	assign key_lt   = (rkey < key_q);
	assign val_eq   = (rval == val_q);
	assign out_free = !out_valid_q || !out_stall;

	// binary search bounds
	assign idx_sx  = signed'({1'b0, CW'(idx_q)});
	assign nlo     = key_lt ? (idx_sx + ONE_SX) : lo_q;
	assign nhi     = key_lt ? hi_q : (idx_sx - ONE_SX);
	assign lkp_end = (nlo > nhi);
	assign msum    = unsigned'(nlo) + unsigned'(nhi);

	always_comb begin
		st          = '0;
		st.out_free = out_free;
		st.init_fin = (mode_q == MODE_INS) ? (full || empty) : empty;
		st.ev_hold  = (mode_q == MODE_REV) && val_eq && pend_v_q && !out_free;
		unique case (mode_q)
			MODE_INS: begin
				st.ev_fin   = !key_gt;
				st.ev_place = key_gt && (idx_q == '0);
			end
			MODE_DEL: st.ev_fin = last_idx;
			MODE_LKP: st.ev_fin = key_eq || lkp_end;
			MODE_REV: st.ev_fin = last_idx;
		endcase
	end

	assign do_eval  = cmd.eval && !st.ev_hold;
	assign rev_emit = do_eval && (mode_q == MODE_REV) && val_eq && pend_v_q;
	assign ins_now  = (cmd.init && (mode_q == MODE_INS) && !full && empty) || cmd.place;

	always_comb begin
		we    = 1'b0;
		waddr = '0;
		wdata = rdata_s1;
		if (ins_now) begin
			we    = 1'b1;
			wdata = {key_q, val_q};
		end
		if (do_eval) begin
			unique case (mode_q)
				MODE_INS: begin
					we    = 1'b1;
					waddr = idx_q + 1'b1;
					wdata = key_gt ? rdata_s1 : {key_q, val_q};
				end
				MODE_DEL: begin
					we    = found_q;
					waddr = idx_q - 1'b1;
				end
				MODE_LKP: we = 1'b0;
				MODE_REV: we = 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (cmd.rd) begin
			rdata_s1 <= mem_q[idx_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			found_q     <= 1'b0;
			pend_v_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (ins_now || (do_eval && (mode_q == MODE_INS) && !key_gt)) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_eval && (mode_q == MODE_DEL) && last_idx && (found_q || key_eq)) begin
				cnt_q <= cnt_m1;
			end
			if (cmd.init) begin
				found_q  <= 1'b0;
				pend_v_q <= 1'b0;
			end else if (do_eval) begin
				if ((mode_q == MODE_DEL) && key_eq) begin
					found_q <= 1'b1;
				end
				if ((mode_q == MODE_REV) && val_eq) begin
					pend_v_q <= 1'b1;
				end
			end
			if (rev_emit || cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q <= mode;
			key_q  <= key_word & TRIM;
			val_q  <= value_word & TRIM;
		end
		if (cmd.init) begin
			pend_st_q  <= ST_MISS;
			pend_key_q <= '0;
			pend_val_q <= '0;
			idx_q      <= '0;
			if (mode_q == MODE_INS) begin
				idx_q <= AW'(cnt_m1);
				if (full) begin
					pend_st_q <= ST_FULL;
				end else if (empty) begin
					pend_st_q  <= ST_DONE;
					pend_key_q <= key_q;
					pend_val_q <= val_q;
				end
			end else if (mode_q == MODE_LKP) begin
				lo_q  <= '0;
				hi_q  <= signed'({1'b0, cnt_m1});
				idx_q <= AW'(cnt_m1 >> 1);
			end
		end
		if (cmd.place) begin
			pend_st_q  <= ST_DONE;
			pend_key_q <= key_q;
			pend_val_q <= val_q;
		end
		if (do_eval) begin
			unique case (mode_q)
				MODE_INS: begin
					idx_q <= idx_q - 1'b1;
					if (!key_gt) begin
						pend_st_q  <= ST_DONE;
						pend_key_q <= key_q;
						pend_val_q <= val_q;
					end
				end
				MODE_DEL: begin
					idx_q <= idx_q + 1'b1;
					if (!found_q && key_eq) begin
						pend_st_q  <= ST_DONE;
						pend_key_q <= rkey;
						pend_val_q <= rval;
					end
				end
				MODE_LKP: begin
					lo_q  <= nlo;
					hi_q  <= nhi;
					idx_q <= AW'(msum >> 1);
					if (key_eq) begin
						pend_st_q  <= ST_DONE;
						pend_key_q <= rkey;
						pend_val_q <= rval;
					end
				end
				MODE_REV: begin
					idx_q <= idx_q + 1'b1;
					if (val_eq) begin
						pend_st_q  <= ST_DONE;
						pend_key_q <= rkey;
						pend_val_q <= rval;
					end
				end
			endcase
		end
		if (rev_emit || cmd.emit) begin
			out_st_q   <= pend_st_q;
			out_key_q  <= pend_key_q;
			out_val_q  <= pend_val_q;
			out_last_q <= cmd.emit;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = out_st_q;
	assign found_key   = out_key_q;
	assign found_value = out_val_q;
	assign last        = out_last_q;

endmodule

>>> hdl/sorted_pair_table_engine_unit.sv
`timescale 1ns / 1ps
// top level of the sorted pair table engine
//
// channel  handshake            payload
// input    in_valid / in_stall  mode, key_word, value_word
// output   out_valid/out_stall  status, found_key, found_value, last
//
// each table entry visited takes one memory read and one compare
// insert walks down from the top, delete and reverse lookup walk the whole table
// lookup is a binary search, one read and one compare per probe
// every request adds an init step before the walk and a result step after; reset needs no clearing pass
// a stalled output holds the walk only when a new result must be sent
module sorted_pair_table_engine_unit #(
	parameter int CAPACITY   = 32,
	parameter int WORD_BYTES = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  mode,
	input  logic [63:0] key_word,
	input  logic [63:0] value_word,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [63:0] found_key,
	output logic [63:0] found_value,
	output logic        last
);
	import spte_pkg::*;

	cmd_t  cmd;
	stat_t st;

	spte_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.st       (st),
		.cmd      (cmd)
	);

	spte_datapath #(
		.CAPACITY   (CAPACITY),
		.WORD_BYTES (WORD_BYTES)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.mode        (mode),
		.key_word    (key_word),
		.value_word  (value_word),
		.cmd         (cmd),
		.st          (st),
		.out_stall   (out_stall),
		.out_valid   (out_valid),
		.status      (status),
		.found_key   (found_key),
		.found_value (found_value),
		.last        (last)
	);

endmodule

>>> hdl/spte_checker.sv
`timescale 1ns / 1ps
// port checks for the sorted pair table engine and their binding
module spte_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic [1:0]  status,
	input logic [63:0] found_key,
	input logic [63:0] found_value,
	input logic        last
);
	import spte_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result transaction dropped while stalled");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == ST_DONE || status == ST_MISS || status == ST_FULL))
		else $error("bad status code");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_MISS |-> last && found_key == '0 && found_value == '0)
		else $error("miss result not empty or not last");

	a_full_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_FULL |-> last && found_key == '0 && found_value == '0)
		else $error("full result not empty or not last");

endmodule

bind sorted_pair_table_engine_unit spte_checker u_spte_checker (.*);

>>> dv/testbench.sv
`timescale 1ns / 1ps
// self-checking testbench for the sorted pair table engine
module testbench;
	import spte_pkg::*;

	localparam int CAP = 32;

	typedef struct packed {
		logic [1:0]  status;
		logic [63:0] pair_key;
		logic [63:0] pair_value;
		logic        last;
	} table_reply_t;

	class table_scoreboard;
		logic [63:0] keys[CAP];
		logic [63:0] values[CAP];
		int count;
		table_reply_t pending[$];
		int errors;

		function new();
			count = 0;
			errors = 0;
		endfunction

		function void push(logic [1:0] st, logic [63:0] k, logic [63:0] v, logic l);
			table_reply_t r;
			r.status = st;
			r.pair_key = k;
			r.pair_value = v;
			r.last = l;
			pending.push_back(r);
		endfunction

		function void note_request(logic [1:0] op, logic [63:0] k, logic [63:0] v);
			int pos;
			int hit;
			int lo;
			int hi;
			int mid;
			int n;
			case (op)
				MODE_INS: begin
					if (count >= CAP) begin
						push(ST_FULL, '0, '0, 1'b1);
					end else begin
						pos = 0;
						while (pos < count && keys[pos] <= k) pos++;
						for (int i = count; i > pos; i--) begin
							keys[i] = keys[i-1];
							values[i] = values[i-1];
						end
						keys[pos] = k;
						values[pos] = v;
						count++;
						push(ST_DONE, k, v, 1'b1);
					end
				end
				MODE_DEL: begin
					hit = -1;
					for (int i = 0; i < count; i++)
						if (hit < 0 && keys[i] == k) hit = i;
					if (hit < 0) begin
						push(ST_MISS, '0, '0, 1'b1);
					end else begin
						push(ST_DONE, keys[hit], values[hit], 1'b1);
						for (int i = hit; i + 1 < count; i++) begin
							keys[i] = keys[i+1];
							values[i] = values[i+1];
						end
						count--;
					end
				end
				MODE_LKP: begin
					lo = 0;
					hi = count - 1;
					hit = -1;
					while (lo <= hi && hit < 0) begin
						mid = lo + (hi - lo) / 2;
						if (keys[mid] == k) hit = mid;
						else if (keys[mid] < k) lo = mid + 1;
						else hi = mid - 1;
					end
					if (hit < 0) push(ST_MISS, '0, '0, 1'b1);
					else push(ST_DONE, keys[hit], values[hit], 1'b1);
				end
				default: begin
					n = 0;
					for (int i = 0; i < count; i++)
						if (values[i] == v) n++;
					if (n == 0) begin
						push(ST_MISS, '0, '0, 1'b1);
					end else begin
						for (int i = 0; i < count; i++)
							if (values[i] == v) begin
								n--;
								push(ST_DONE, keys[i], values[i], n == 0);
							end
					end
				end
			endcase
		endfunction

		function void check_reply(logic [1:0] st, logic [63:0] k, logic [63:0] v, logic l);
			table_reply_t e;
			if (pending.size() == 0) begin
				$error("unexpected result status=%0d key=%h value=%h", st, k, v);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (st !== e.status) begin
				$error("status expected %0d actual %0d", e.status, st);
				errors++;
			end
			if (k !== e.pair_key) begin
				$error("found_key expected %h actual %h", e.pair_key, k);
				errors++;
			end
			if (v !== e.pair_value) begin
				$error("found_value expected %h actual %h", e.pair_value, v);
				errors++;
			end
			if (l !== e.last) begin
				$error("last expected %0d actual %0d", e.last, l);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  mode = MODE_INS;
	logic [63:0] key_word = '0;
	logic [63:0] value_word = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [1:0]  status;
	logic [63:0] found_key;
	logic [63:0] found_value;
	logic        last;

	int send_idle = 37;
	int recv_idle = 64;
	int hold_cycles = 0;
	logic hold_req = 1'b0;
	logic hold_done = 1'b0;
	int sent_count = 0;
	table_scoreboard board;
	logic [63:0] key_pool[8];
	logic [63:0] value_pool[4];

	sorted_pair_table_engine_unit i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.mode(mode),
		.key_word(key_word),
		.value_word(value_word),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.found_key(found_key),
		.found_value(found_value),
		.last(last)
	);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	initial begin
		board = new();
		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
	end

	// receiver: random stall, or a long hold-off when requested
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall)
				board.check_reply(status, found_key, found_value, last);
			if (hold_cycles > 0) begin
				hold_cycles <= hold_cycles - 1;
				out_stall <= 1'b1;
			end else if (hold_req && !hold_done) begin
				hold_cycles <= 300;
				hold_done <= 1'b1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(99) < recv_idle);
			end
		end
	end

	task automatic send_request(logic [1:0] op, logic [63:0] k, logic [63:0] v);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= op;
		key_word <= k;
		value_word <= v;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		board.note_request(op, k, v);
		sent_count++;
	endtask

	task automatic send_random(int n);
		logic [1:0] op;
		logic [63:0] k;
		logic [63:0] v;
		for (int i = 0; i < n; i++) begin
			op = 2'($urandom_range(3));
			if ($urandom_range(99) < 10) op = MODE_INS;
			k = ($urandom_range(99) < 80) ? key_pool[$urandom_range(7)]
				: {$urandom, $urandom};
			v = ($urandom_range(99) < 75) ? value_pool[$urandom_range(3)]
				: {$urandom, $urandom};
			send_request(op, k, v);
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	initial begin
		@(posedge arst_n);
		@(posedge clk);
		for (int i = 0; i < 8; i++) key_pool[i] = {$urandom, $urandom};
		key_pool[0] = '0;
		key_pool[7] = '1;
		value_pool[0] = '0;
		value_pool[1] = '1;
		value_pool[2] = {$urandom, $urandom};
		value_pool[3] = 64'h4142_4300_0000_0000;

		// empty table corner cases
		send_request(MODE_DEL, 64'h1, '0);
		send_request(MODE_LKP, '0, '0);
		send_request(MODE_REV, '0, '0);
		// extremes and duplicates
		send_request(MODE_INS, '1, '1);
		send_request(MODE_INS, '0, '0);
		send_request(MODE_INS, '0, '1);
		send_request(MODE_INS, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
		send_request(MODE_INS, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555);
		send_request(MODE_INS, '0, '1);
		send_request(MODE_LKP, '0, '0);
		send_request(MODE_LKP, '1, '0);
		send_request(MODE_LKP, 64'h1234, '0);
		send_request(MODE_REV, '0, '1);
		send_request(MODE_REV, '0, 64'h77);
		send_request(MODE_DEL, '0, '0);
		send_request(MODE_DEL, 64'h1234, '0);
		// fill to capacity, then overflow
		while (board.count < CAP)
			send_request(MODE_INS, key_pool[$urandom_range(7)], value_pool[$urandom_range(1)]);
		send_request(MODE_INS, 64'h42, 64'h43);
		send_request(MODE_REV, '0, '1);
		send_request(MODE_REV, '0, '0);

		// long receiver hold-off while the sender keeps going
		hold_req = 1'b1;
		send_random(20);
		send_random(20);
		drain();

		send_idle = 64;
		recv_idle = 37;
		send_random(50);
		drain();

		send_idle = 0;
		recv_idle = 0;
		send_random(50);
		drain();

		if (board.errors == 0 && board.pending.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule

>>> filelist.f
hdl/spte_pkg.sv
hdl/spte_ctrl.sv
hdl/spte_datapath.sv
hdl/sorted_pair_table_engine_unit.sv
hdl/spte_checker.sv
dv/testbench.sv
